// File: rtl/trsp_pkg.sv
// shared types and constants for the tagged record stream parser
// no dependencies; imported by every rtl file of the block
package trsp_pkg;

    // parser position inside an entry
    typedef enum logic [1:0] {
        PH_TYPE = 2'd0,
        PH_HEAD = 2'd1,
        PH_PAY  = 2'd2
    } trsp_phase_t;

    // result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_END_OK  = 2'd2;
    localparam logic [1:0] KIND_END_EOD = 2'd3;

    // header forms, low two type bits
    localparam logic [1:0] FORM_FIXED8 = 2'd0;
    localparam logic [1:0] FORM_FIXED4 = 2'd1;
    localparam logic [1:0] FORM_VARINT = 2'd2;
    localparam logic [1:0] FORM_VARNEG = 2'd3;

    localparam logic [7:0] CONT_MASK     = 8'h80;
    localparam logic [7:0] GROUP_MASK    = 8'h7F;
    localparam int         VALUE_BIT     = 3;      // type bit: header is a value, no payload
    localparam logic [3:0] VARINT_GROUPS = 4'd10;
    localparam logic [3:0] FIXED8_BYTES  = 4'd8;
    localparam logic [3:0] FIXED4_BYTES  = 4'd4;

    // default depth of the result queue
    localparam int RES_DEPTH_DEF = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  entry_type;
        logic [63:0] header_value;
        logic [7:0]  payload_byte;
        logic        last_of_run;
    } trsp_result_t;

endpackage

// File: rtl/trsp_core.sv
// per-word parse step: entry state registers and the results of one word
// depends on trsp_pkg
module trsp_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step_fire,
    input  logic [7:0]             in_byte,
    input  logic                   buffer_end,
    output trsp_pkg::trsp_result_t res0,
    output trsp_pkg::trsp_result_t res1,
    output logic [1:0]             res_count
);
    import trsp_pkg::*;

    trsp_phase_t phase_reg, phase_next;
    logic [7:0]  held_type_reg, held_type_next;
    logic [3:0]  header_index_reg, header_index_next;
    logic [63:0] header_accum_reg, header_accum_next;
    logic [63:0] payload_left_reg, payload_left_next;

    logic [1:0]  form;
    logic [3:0]  idx_inc;
    logic [63:0] fixed_term;
    logic [63:0] fixed_accum;
    logic        fixed_done;
    logic [6:0]  var_shamt;
    logic [63:0] var_term;
    logic [63:0] var_accum;
    logic [3:0]  var_idx;
    logic [63:0] head_accum;
    logic [3:0]  head_idx;
    logic        head_done;
    logic [63:0] head_final;
    logic        has_payload;
    logic        head_emit;
    logic        pay_emit;
    logic        pay_last;
    logic        complete;
    logic [7:0]  end_type;
    trsp_result_t main_res;
    trsp_result_t end_res;

    assign form    = held_type_reg[1:0];
    assign idx_inc = header_index_reg + 4'd1;

    // fixed little-endian form
    assign fixed_term  = {56'd0, in_byte} << {header_index_reg[2:0], 3'b000};
    assign fixed_accum = (header_index_reg < FIXED8_BYTES) ? (header_accum_reg | fixed_term)
                                                          : header_accum_reg;
    assign fixed_done  = (form == FORM_FIXED4) ? (idx_inc >= FIXED4_BYTES)
                                               : (idx_inc >= FIXED8_BYTES);

    // varint form, 7 bits a group, groups past the tenth dropped
    assign var_shamt = ({3'd0, header_index_reg} << 3) - {3'd0, header_index_reg};
    assign var_term  = {56'd0, in_byte & GROUP_MASK} << var_shamt;
    assign var_accum = (header_index_reg < VARINT_GROUPS) ? (header_accum_reg | var_term)
                                                          : header_accum_reg;
    assign var_idx   = (header_index_reg < VARINT_GROUPS) ? idx_inc : header_index_reg;

    assign head_accum  = form[1] ? var_accum : fixed_accum;
    assign head_idx    = form[1] ? var_idx : idx_inc;
    assign head_done   = form[1] ? ((in_byte & CONT_MASK) == 8'd0) : fixed_done;
    assign head_final  = (form == FORM_VARNEG) ? (64'd0 - head_accum) : head_accum;
    // negation keeps zero at zero, so the unnegated sum decides
    assign has_payload = !held_type_reg[VALUE_BIT] && (head_accum != 64'd0);

    assign head_emit = (phase_reg == PH_HEAD) && head_done;
    assign pay_emit  = (phase_reg == PH_PAY);
    assign pay_last  = (payload_left_reg == 64'd1);
    assign complete  = (head_emit && !has_payload) || (pay_emit && pay_last);
    assign end_type  = (phase_reg == PH_TYPE) ? in_byte : held_type_reg;

    // next state
    always_comb
    begin
        phase_next        = phase_reg;
        held_type_next    = held_type_reg;
        header_index_next = header_index_reg;
        header_accum_next = header_accum_reg;
        payload_left_next = payload_left_reg;
        case (phase_reg)
            PH_TYPE:
            begin
                held_type_next    = in_byte;
                header_index_next = 4'd0;
                header_accum_next = 64'd0;
                payload_left_next = 64'd0;
                phase_next        = PH_HEAD;
            end
            PH_HEAD:
            begin
                header_accum_next = head_accum;
                header_index_next = head_idx;
                if (head_done)
                begin
                    header_accum_next = head_final;
                    header_index_next = 4'd0;
                    if (has_payload)
                    begin
                        payload_left_next = head_final;
                        phase_next        = PH_PAY;
                    end
                    else
                    begin
                        phase_next = PH_TYPE;
                    end
                end
            end
            PH_PAY:
            begin
                payload_left_next = payload_left_reg - 64'd1;
                if (pay_last)
                begin
                    phase_next = PH_TYPE;
                end
            end
            default:
            begin
                phase_next = PH_TYPE;
            end
        endcase
        if (buffer_end)
        begin
            phase_next        = PH_TYPE;
            held_type_next    = 8'd0;
            header_index_next = 4'd0;
            header_accum_next = 64'd0;
            payload_left_next = 64'd0;
        end
    end

    // results of this word
    always_comb
    begin
        main_res = '0;
        case (phase_reg)
            PH_HEAD:
            begin
                main_res.kind         = KIND_HEADER;
                main_res.entry_type   = held_type_reg;
                main_res.header_value = head_final;
            end
            PH_PAY:
            begin
                main_res.kind         = KIND_PAYLOAD;
                main_res.entry_type   = held_type_reg;
                main_res.header_value = header_accum_reg;
                main_res.payload_byte = in_byte;
            end
            default:
            begin
                main_res = '0;
            end
        endcase
        main_res.last_of_run = !buffer_end;

        end_res             = '0;
        end_res.kind        = complete ? KIND_END_OK : KIND_END_EOD;
        end_res.entry_type  = end_type;
        end_res.last_of_run = 1'b1;

        if (head_emit || pay_emit)
        begin
            res0      = main_res;
            res1      = end_res;
            res_count = buffer_end ? 2'd2 : 2'd1;
        end
        else
        begin
            res0      = end_res;
            res1      = end_res;
            res_count = buffer_end ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_TYPE;
            held_type_reg    <= 8'd0;
            header_index_reg <= 4'd0;
            header_accum_reg <= 64'd0;
            payload_left_reg <= 64'd0;
        end
        else if (step_fire)
        begin
            phase_reg        <= phase_next;
            held_type_reg    <= held_type_next;
            header_index_reg <= header_index_next;
            header_accum_reg <= header_accum_next;
            payload_left_reg <= payload_left_next;
        end
    end

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && buffer_end) |=> (phase_reg == PH_TYPE && header_accum_reg == 64'd0
                                       && payload_left_reg == 64'd0))
        else $error("state not cleared after buffer end");

    a_two_results_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_count == 2'd2) |-> ((res1.kind == KIND_END_OK || res1.kind == KIND_END_EOD)
                                 && res1.last_of_run && !res0.last_of_run))
        else $error("second result of a word is not a final end status");

    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAY) |-> (payload_left_reg != 64'd0))
        else $error("payload phase with nothing left");

    a_fixed_index: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEAD && !held_type_reg[1]) |-> (header_index_reg < FIXED8_BYTES))
        else $error("fixed header index out of range");

endmodule

// File: rtl/trsp_rfifo.sv
// small result queue taking up to two results per cycle, one out per cycle
// depends on trsp_pkg
module trsp_rfifo #(
    parameter int DEPTH = trsp_pkg::RES_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [1:0]             push_count,
    input  trsp_pkg::trsp_result_t push0,
    input  trsp_pkg::trsp_result_t push1,
    input  logic                   pop,
    output trsp_pkg::trsp_result_t head,
    output logic                   not_empty,
    output logic                   room2
);
    import trsp_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    trsp_result_t    mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [PW-1:0]   wr_ptr_p1;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PW'(1);
        end
        return r;
    endfunction

    assign wr_ptr_p1 = ptr_inc(wr_ptr_reg);
    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign room2     = (count_reg <= CW'(DEPTH - 2));

    always_comb
    begin
        case (push_count)
            2'd1:    wr_ptr_next = wr_ptr_p1;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_p1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push_count) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            mem_reg[wr_ptr_p1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("result queue count beyond depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_count != 2'd0) |-> room2)
        else $error("result queue pushed without room for two");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("result queue popped while empty");

endmodule

// File: rtl/tagged_record_stream_parser_top.sv
// tagged record stream parser, top level: input word register, parse step, result queue
// depends on trsp_pkg, trsp_core, trsp_rfifo
//
// the block parses a serialized buffer of type-length-value entries, one byte word per
// cycle while the result queue has room. each entry is a type byte and a header number
// whose form the low two type bits choose (8 or 4 fixed little-endian bytes, a 7-bit-group
// varint, or a varint negated in 64 bits); when type bit 3 is clear the header is a
// payload length and that many bytes follow. results are record headers, payload bytes and,
// on the word flagged buffer_end, an end status (ok, or end-of-data inside an entry) after
// which the parser starts over. a word sits in the input register, the parse step settles
// state and up to two results from it combinationally, and the results enter a small queue.
// in_ready stays high while the queue can take two more results, so with out_ready high
// the block takes one word per cycle; a word that yields two results (a buffer end on a word
// that closes a header or carries a payload byte) puts both into the queue at once. an
// accepted word passes the input register and the result queue before its first result.
module tagged_record_stream_parser_top #(
    parameter int RES_DEPTH = trsp_pkg::RES_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        buffer_end,
    // results
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  entry_type,
    output logic [63:0] header_value,
    output logic [7:0]  payload_byte,
    output logic        last_of_run
);
    import trsp_pkg::*;

    // input word register
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       end_reg;

    logic         step_fire;
    logic         room2;
    logic         not_empty;
    logic         pop;
    logic [1:0]   res_count;
    logic [1:0]   push_count;
    trsp_result_t res0;
    trsp_result_t res1;
    trsp_result_t head;

    // the held word is parsed once the queue has room for both of its possible results
    assign step_fire = in_valid_reg && room2;
    assign in_ready  = !in_valid_reg || step_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // payload of the word register, loaded on accept
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
            end_reg  <= buffer_end;
        end
    end

    trsp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_fire  (step_fire),
        .in_byte    (byte_reg),
        .buffer_end (end_reg),
        .res0       (res0),
        .res1       (res1),
        .res_count  (res_count)
    );

    // results only count when the step actually fires
    assign push_count = step_fire ? res_count : 2'd0;
    assign pop        = not_empty && out_ready;

    trsp_rfifo #(
        .DEPTH (RES_DEPTH)
    ) u_rfifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (res0),
        .push1      (res1),
        .pop        (pop),
        .head       (head),
        .not_empty  (not_empty),
        .room2      (room2)
    );

    // result channel straight from the queue head
    assign out_valid    = not_empty;
    assign kind         = head.kind;
    assign entry_type   = head.entry_type;
    assign header_value = head.header_value;
    assign payload_byte = head.payload_byte;
    assign last_of_run  = head.last_of_run;

endmodule

// File: tb/sv/tb.sv
// testbench for tagged_record_stream_parser_top: byte words in, record results out
// depends on trsp_pkg and the rtl of the block; self-checking against a built-in parser
// driver and monitor are clocked always blocks, stimulus comes from a queue filled below
`timescale 1ns / 1ps

module tb;
    import trsp_pkg::*;

    // run shape
    localparam int RANDOM_WORDS = 1225;  // random words after the directed part
    localparam int QUIET_LIMIT  = 4000;  // cycles with no handshake on either side
    localparam int DRAIN_CYCLES = 16;    // pause at the end for stray results
    localparam int MAX_REPORTS  = 10;

    // one input word as the driver presents it
    typedef struct packed {
        logic [7:0] data;
        logic       is_end;
    } word_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    // block ports, inputs all known from time zero
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte    = 8'h00;
    logic        buffer_end = 1'b0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  entry_type;
    logic [63:0] header_value;
    logic [7:0]  payload_byte;
    logic        last_of_run;

    tagged_record_stream_parser_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .buffer_end   (buffer_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .entry_type   (entry_type),
        .header_value (header_value),
        .payload_byte (payload_byte),
        .last_of_run  (last_of_run)
    );

    // stimulus and bookkeeping
    word_t        buffer_q [$];     // words waiting for the driver
    logic [7:0]   staged [$];       // bytes of the buffer being built
    trsp_result_t record_q [$];     // parser results still to come out of the block
    int           words_issued   = 0;
    int           words_accepted = 0;
    int           results_seen   = 0;
    int           mismatches     = 0;
    int           quiet_cycles   = 0;
    int           kind_count [4] = '{0, 0, 0, 0};
    int           send_idle_pct  = 26;
    int           recv_idle_pct  = 46;
    logic         word_taken     = 1'b0;
    word_t        next_word;
    trsp_result_t got, want;

    // parser state, same reset values as the block
    trsp_phase_t parse_phase = PH_TYPE;
    logic [7:0]  cur_type    = 8'h00;
    logic [3:0]  hdr_count   = 4'd0;
    logic [63:0] hdr_value   = 64'd0;
    logic [63:0] bytes_owed  = 64'd0;

    // ------------------------------------------------------------------
    // parser: one accepted word in, zero to two results queued
    // ------------------------------------------------------------------

    function automatic trsp_result_t make_result(input logic [1:0] k, input logic [63:0] v,
                                                 input logic [7:0] pb);
        trsp_result_t r;
        r.kind         = k;
        r.entry_type   = cur_type;
        r.header_value = v;
        r.payload_byte = pb;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic is_end);
        trsp_result_t res [2];
        int           n;
        logic         done;
        logic         complete;
        logic [1:0]   form;
        n        = 0;
        done     = 1'b0;
        complete = 1'b0;
        form     = cur_type[1:0];
        case (parse_phase)
            PH_TYPE:
            begin
                cur_type    = b;
                hdr_count   = 4'd0;
                hdr_value   = 64'd0;
                bytes_owed  = 64'd0;
                parse_phase = PH_HEAD;
            end
            PH_HEAD:
            begin
                if (!form[1])
                begin
                    // fixed little-endian header, 8 or 4 bytes
                    if (hdr_count < FIXED8_BYTES)
                        hdr_value |= {56'd0, b} << (8 * hdr_count);
                    hdr_count++;
                    done = hdr_count >= ((form == FORM_FIXED8) ? FIXED8_BYTES : FIXED4_BYTES);
                end
                else
                begin
                    // varint: groups past the tenth add nothing, the tenth only bit 63
                    if (hdr_count < VARINT_GROUPS)
                    begin
                        hdr_value |= {57'd0, b[6:0]} << (7 * hdr_count);
                        hdr_count++;
                    end
                    done = (b & CONT_MASK) == 8'h00;
                end
                if (done)
                begin
                    if (form == FORM_VARNEG)
                        hdr_value = -hdr_value;
                    res[n] = make_result(KIND_HEADER, hdr_value, 8'h00);
                    n++;
                    hdr_count = 4'd0;
                    if (!cur_type[VALUE_BIT] && hdr_value != 64'd0)
                    begin
                        bytes_owed  = hdr_value;
                        parse_phase = PH_PAY;
                    end
                    else
                    begin
                        parse_phase = PH_TYPE;
                        complete    = 1'b1;
                    end
                end
            end
            default:
            begin
                res[n] = make_result(KIND_PAYLOAD, hdr_value, b);
                n++;
                bytes_owed--;
                if (bytes_owed == 64'd0)
                begin
                    parse_phase = PH_TYPE;
                    complete    = 1'b1;
                end
            end
        endcase
        if (is_end)
        begin
            res[n] = make_result(complete ? KIND_END_OK : KIND_END_EOD, 64'd0, 8'h00);
            n++;
            parse_phase = PH_TYPE;
            cur_type    = 8'h00;
            hdr_count   = 4'd0;
            hdr_value   = 64'd0;
            bytes_owed  = 64'd0;
        end
        if (n > 0)
            res[n - 1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            record_q.push_back(res[i]);
    endtask

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------

    task automatic push_word(input logic [7:0] b, input logic is_end);
        buffer_q.push_back({b, is_end});
        words_issued++;
    endtask

    task automatic stage_fixed(input logic [63:0] v, input int nbytes);
        for (int i = 0; i < nbytes; i++)
            staged.push_back(v[8 * i +: 8]);
    endtask

    // minimal groups plus pad; bits above bit 63 and groups past the tenth carry junk
    task automatic stage_varint(input logic [63:0] v, input int pad);
        int         groups;
        logic [6:0] g;
        logic [7:0] r;
        groups = 1;
        while (groups < 10 && (v >> (7 * groups)) != 64'd0)
            groups++;
        groups += pad;
        for (int i = 0; i < groups; i++)
        begin
            r = 8'($urandom);
            if (i < 9)
                g = v[7 * i +: 7];
            else if (i == 9)
                g = {r[6:1], v[63]};
            else
                g = r[6:0];
            staged.push_back({(i < groups - 1), g});
        end
    endtask

    task automatic stage_entry();
        logic [7:0]  etype;
        logic [1:0]  form;
        logic        is_value;
        logic [63:0] v;
        int          len;
        int          pad;
        form     = 2'($urandom_range(0, 3));
        is_value = ($urandom_range(0, 2) == 0);
        etype    = 8'($urandom);    // bit 2 and the top nibble ride along at random
        etype[1:0]       = form;
        etype[VALUE_BIT] = is_value;
        pad = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
        staged.push_back(etype);
        if (is_value)
        begin
            case ($urandom_range(0, 3))
                0:       v = 64'd0;
                1:       v = '1;
                default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            endcase
            case (form)
                FORM_FIXED8: stage_fixed(v, 8);
                FORM_FIXED4: stage_fixed(v, 4);
                default:     stage_varint(v, pad);
            endcase
        end
        else
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
            v   = 64'(len);
            case (form)
                FORM_FIXED8: stage_fixed(v, 8);
                FORM_FIXED4: stage_fixed(v, 4);
                FORM_VARINT: stage_varint(v, pad);
                default:     stage_varint(-v, pad);  // negated: ten or more groups for a nonzero length
            endcase
            repeat (len)
                staged.push_back(8'($urandom));
        end
    endtask

    // one buffer: mostly whole entries, some cut short, a few of plain noise
    task automatic queue_buffer(output int count);
        int style;
        int keep;
        staged.delete();
        style = $urandom_range(0, 99);
        if (style < 10)
        begin
            repeat ($urandom_range(1, 8))
                staged.push_back(8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                stage_entry();
            if (style < 30 && staged.size() > 1)
            begin
                keep = $urandom_range(1, staged.size() - 1);
                while (staged.size() > keep)
                    void'(staged.pop_back());
            end
        end
        for (int i = 0; i < staged.size(); i++)
            push_word(staged[i], (i == staged.size() - 1) ||
                                 (style < 10 && $urandom_range(0, 7) == 0));
        count = staged.size();
    endtask

    task automatic queue_random_phase(input int target);
        int added;
        int n;
        added = 0;
        while (added < target)
        begin
            queue_buffer(n);
            added += n;
        end
    endtask

    // every word taken and every result seen
    task automatic wait_drained();
        do
            @(negedge clk);
        while (words_accepted != words_issued || record_q.size() != 0);
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // driver: new words and out_ready change on the falling edge
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        // a word stays put until it is taken
        if (!in_valid || word_taken)
        begin
            if (buffer_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_word   = buffer_q.pop_front();
                in_valid   <= 1'b1;
                in_byte    <= next_word.data;
                buffer_end <= next_word.is_end;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: both handshakes sampled on the rising edge, plus the watchdog
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            word_taken <= in_valid && in_ready;
            // predict before checking, so a same-edge result would still find its entry
            if (in_valid && in_ready)
            begin
                parse_byte(in_byte, buffer_end);
                words_accepted++;
            end
            if (out_valid && out_ready)
            begin
                got = {kind, entry_type, header_value, payload_byte, last_of_run};
                results_seen++;
                kind_count[kind]++;
                if (record_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: unexpected result kind %0d type %02h value %016h",
                                 got.kind, got.entry_type, got.header_value);
                end
                else
                begin
                    want = record_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"mismatch: expected kind %0d type %02h value %016h ",
                                      "byte %02h last %b, got kind %0d type %02h value %016h ",
                                      "byte %02h last %b"},
                                     want.kind, want.entry_type, want.header_value,
                                     want.payload_byte, want.last_of_run,
                                     got.kind, got.entry_type, got.header_value,
                                     got.payload_byte, got.last_of_run);
                    end
                end
            end
            // watchdog on handshakes, not on elapsed time
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         quiet_cycles, record_q.size());
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------

    initial
    begin
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles a quarter of the time, receiver nearly half
        send_idle_pct = 26;
        recv_idle_pct = 46;

        // fixed4 value of all ones
        push_word(8'h09, 1'b0);
        repeat (4)
            push_word(8'hFF, 1'b0);
        // zero length varint with bit 2 and the top nibble set: header only
        push_word(8'hF6, 1'b0);
        push_word(8'h00, 1'b0);
        // long varint value: eleven groups, tenth gives bit 63, eleventh is dropped
        push_word(8'h0A, 1'b0);
        push_word(8'h81, 1'b0);
        repeat (8)
            push_word(8'h80, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'h7F, 1'b0);
        // negated varint of one, buffer ends on the same word: header plus end ok
        push_word(8'h0B, 1'b0);
        push_word(8'h01, 1'b1);
        // buffer ends inside a fixed8 header
        push_word(8'h00, 1'b0);
        push_word(8'h34, 1'b0);
        push_word(8'h12, 1'b1);
        // buffer ends on a lone type byte
        push_word(8'hFF, 1'b1);

        queue_random_phase(RANDOM_WORDS / 3);
        wait_drained();

        // receiver mostly ready, sender slow
        send_idle_pct = 46;
        recv_idle_pct = 26;
        queue_random_phase(RANDOM_WORDS / 3);
        wait_drained();

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_phase(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3));
        wait_drained();

        // anything arriving now has no entry and counts as a mismatch
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("summary: %0d words parsed into %0d results, %0d headers, %0d payload bytes",
                 words_accepted, results_seen, kind_count[KIND_HEADER],
                 kind_count[KIND_PAYLOAD]);
        $display("summary: %0d buffers closed cleanly, %0d cut inside an entry, %0d mismatches",
                 kind_count[KIND_END_OK], kind_count[KIND_END_EOD], mismatches);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// File: tagged_record_stream_parser_top.f
rtl/trsp_pkg.sv
rtl/trsp_core.sv
rtl/trsp_rfifo.sv
rtl/tagged_record_stream_parser_top.sv
tb/sv/tb.sv
